>>> rtl/core/pfr_pkg.sv
package pfr_pkg;

    // result status codes
    typedef enum logic [2:0] {
        ST_FREE     = 3'd0,
        ST_EVICT    = 3'd1,
        ST_RESIDENT = 3'd2,
        ST_DIRTY    = 3'd3,
        ST_IGNORED  = 3'd4
    } t_status;

    // request kinds
    localparam logic OP_FAULT = 1'b0;
    localparam logic OP_MARK  = 1'b1;

    // configuration register indexes
    localparam int          CFG_INDEX_W     = 2;
    localparam int          CFG_DATA_W      = 16;
    localparam logic [1:0]  CFG_PAGE_COUNT  = 2'd0;
    localparam logic [1:0]  CFG_FRAME_COUNT = 2'd1;
    localparam logic [1:0]  CFG_RANDOM_SEED = 2'd2;

    localparam int          PAGE_COUNT_W      = 9;
    localparam int          FRAME_COUNT_W     = 7;
    localparam logic [8:0]  PAGE_COUNT_RESET  = 9'd256;
    localparam logic [6:0]  FRAME_COUNT_RESET = 7'd64;

    // victim choice lfsr
    localparam int          LFSR_W     = 16;
    localparam logic [15:0] LFSR_MASK  = 16'hB400;
    localparam logic [15:0] SEED_RESET = 16'd44257;

    // field widths
    localparam int PAGE_W    = 8;
    localparam int FRAME_O_W = 6;
    localparam int COUNT_W   = 32;
    localparam int STATUS_W  = 3;

    // result tdata layout, lowest bit first
    localparam int OUT_FRAME_LSB  = 0;
    localparam int OUT_VICTIM_LSB = OUT_FRAME_LSB + FRAME_O_W;
    localparam int OUT_WB_BIT     = OUT_VICTIM_LSB + PAGE_W;
    localparam int OUT_COUNT_LSB  = OUT_WB_BIT + 1;
    localparam int OUT_USED_W     = OUT_COUNT_LSB + COUNT_W;
    localparam int OUT_TDATA_W    = ((OUT_USED_W + 7) / 8) * 8;
    localparam int IN_TDATA_W     = 8;

endpackage

>>> rtl/core/pfr_ram.sv
module pfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/page_fault_random_replacement.sv
// Demand-paging pager with random victim choice. One request is worked on at a
// time; the page table (resident, dirty and frame of every page) lives in one
// synchronous RAM with a registered read, and each step of a request is a read,
// a check and a write back of one table entry. After reset a clearing pass
// writes every table entry, during which no request transfer is taken
// (configuration writes are taken as ever). A mark, a hit or a fault that finds
// a free frame takes a table lookup, a request beyond the page count none, and
// each then waits for the result slot. A fault that must evict draws until it
// finds a resident victim, where each draw is one lfsr step, a remainder unit
// (4 bits a cycle) and a table read and check, then maps the frame; the expected
// draw count is page count over resident pages below it. A fault with no
// resident page below the page count runs the full lfsr period (65535 draws)
// before it is reported as ignored, which leaves the lfsr where it started. Frames
// are handed out lowest first and never freed, so the frames in use always form a
// prefix and are tracked as a fill count. A result waits in an output register, so
// the next request transfer can be taken while it is not yet collected.
module page_fault_random_replacement
    import pfr_pkg::*;
#(
    parameter int MAX_PAGES  = 256,
    parameter int MAX_FRAMES = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // request stream
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [IN_TDATA_W-1:0]   i_s_tdata,   // requested_page[7:0]
    input  logic                    i_s_tuser,   // operation[0]
    // result stream
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    // mapped_frame[5:0], evicted_page[13:6], write_back[14],
    // disk_accesses[46:15], zero fill[47]
    output logic [OUT_TDATA_W-1:0]  o_m_tdata,
    output logic [STATUS_W-1:0]     o_m_tuser,   // status[2:0]
    // configuration writes
    input  logic                    i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int PAW      = $clog2(MAX_PAGES);
    localparam int PCW      = $clog2(MAX_PAGES + 1);
    localparam int FW       = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int FCW      = $clog2(MAX_FRAMES + 1);
    localparam int EW       = FW + 2;          // table entry: resident, dirty, frame
    localparam int E_RES    = FW + 1;
    localparam int E_DIRTY  = FW;
    localparam int MOD_STEP = 4;               // remainder bits per cycle
    localparam int MOD_CYC  = LFSR_W / MOD_STEP;
    localparam int MCW      = (MOD_CYC > 1) ? $clog2(MOD_CYC) : 1;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_LOOK  = 9'b000000100,
        S_DRAW  = 9'b000001000,
        S_MOD   = 9'b000010000,
        S_VRD   = 9'b000100000,
        S_VCHK  = 9'b001000000,
        S_MAP   = 9'b010000000,
        S_EMIT  = 9'b100000000
    } t_state;

    t_state                     r_state;
    logic [PAW-1:0]             r_clr;
    logic [PAGE_COUNT_W-1:0]    r_page_count;
    logic [FRAME_COUNT_W-1:0]   r_frame_count;
    logic [LFSR_W-1:0]          r_lfsr;
    logic [COUNT_W-1:0]         r_acc;
    logic [FCW-1:0]             r_used;
    logic                       r_op;
    logic [PAW-1:0]             r_page;
    logic [LFSR_W-1:0]          r_draws;
    logic [LFSR_W-1:0]          r_div;
    logic [PCW-1:0]             r_rem;
    logic [MCW-1:0]             r_mcnt;
    t_status                    r_res_status;
    logic [FW-1:0]              r_res_frame;
    logic [PAW-1:0]             r_victim;
    logic                       r_res_wb;
    logic                       r_out_valid;
    logic [OUT_TDATA_W-1:0]     r_out_tdata;
    logic [STATUS_W-1:0]        r_out_tuser;

    logic [PCW-1:0]             pc_eff;
    logic [FCW-1:0]             fc_eff;
    logic                       in_xfer;
    logic                       page_ok;
    logic                       ram_we;
    logic [PAW-1:0]             ram_waddr;
    logic [EW-1:0]              ram_wdata;
    logic                       ram_re;
    logic [PAW-1:0]             ram_raddr;
    logic [EW-1:0]              ram_rdata;
    logic [PCW-1:0]             mod_rem;
    logic [LFSR_W-1:0]          mod_div;
    logic [PCW:0]               mod_t;
    logic                       slot_free;

    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] n;
        n = v >> 1;
        if (v[0]) begin
            n = n ^ LFSR_MASK;
        end
        if (n == '0) begin
            n = LFSR_W'(1);
        end
        return n;
    endfunction

    // counter add that sticks at all ones
    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                   input logic [1:0] inc);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {{(COUNT_W - 1){1'b0}}, inc};
        return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
    endfunction

    // zero acts as one, anything above the table size as the table size
    always_comb begin
        if (r_page_count == '0) begin
            pc_eff = PCW'(1);
        end else if (r_page_count > MAX_PAGES) begin
            pc_eff = PCW'(MAX_PAGES);
        end else begin
            pc_eff = PCW'(r_page_count);
        end
        if (r_frame_count == '0) begin
            fc_eff = FCW'(1);
        end else if (r_frame_count > MAX_FRAMES) begin
            fc_eff = FCW'(MAX_FRAMES);
        end else begin
            fc_eff = FCW'(r_frame_count);
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign in_xfer    = i_s_tvalid && o_s_tready;
    assign page_ok    = (i_s_tdata[PAGE_W-1:0] < pc_eff);
    assign slot_free  = !r_out_valid || i_m_tready;

    // remainder of the lfsr value by the page count, MOD_STEP bits a cycle
    always_comb begin
        mod_rem = r_rem;
        mod_div = r_div;
        mod_t   = '0;
        for (int j = 0; j < MOD_STEP; j++) begin
            mod_t   = {mod_rem, mod_div[LFSR_W-1]};
            mod_div = mod_div << 1;
            if (mod_t >= {1'b0, pc_eff}) begin
                mod_t = mod_t - {1'b0, pc_eff};
            end
            mod_rem = mod_t[PCW-1:0];
        end
    end

    // page table port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_page;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = PAW'(i_s_tdata[PAGE_W-1:0]);
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
            end
            S_IDLE: begin
                ram_re = in_xfer;
            end
            S_LOOK: begin
                if (r_op == OP_MARK) begin
                    ram_we    = ram_rdata[E_RES];
                    ram_wdata = {2'b11, ram_rdata[FW-1:0]};
                end else if (!ram_rdata[E_RES] && (r_used < fc_eff)) begin
                    ram_we    = 1'b1;
                    ram_wdata = {2'b10, FW'(r_used)};
                end
            end
            S_VRD: begin
                ram_re    = 1'b1;
                ram_raddr = PAW'(r_rem);
            end
            S_VCHK: begin
                // unmap the victim, clean
                ram_we    = ram_rdata[E_RES];
                ram_waddr = PAW'(r_rem);
            end
            S_MAP: begin
                ram_we    = 1'b1;
                ram_wdata = {2'b10, r_res_frame};
            end
            S_DRAW, S_MOD, S_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    pfr_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_PAGES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_page_count  <= PAGE_COUNT_RESET;
            r_frame_count <= FRAME_COUNT_RESET;
            r_lfsr        <= SEED_RESET;
            r_acc         <= '0;
            r_used        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + PAW'(1);
                    if (r_clr == PAW'(MAX_PAGES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_xfer) begin
                        r_op         <= i_s_tuser;
                        r_page       <= PAW'(i_s_tdata[PAGE_W-1:0]);
                        r_res_status <= ST_IGNORED;
                        r_res_frame  <= '0;
                        r_victim     <= '0;
                        r_res_wb     <= 1'b0;
                        r_draws      <= '0;
                        // a page beyond the count needs no table lookup
                        r_state      <= page_ok ? S_LOOK : S_EMIT;
                    end
                end
                S_LOOK: begin
                    r_state <= S_EMIT;
                    if (r_op == OP_MARK) begin
                        if (ram_rdata[E_RES]) begin
                            r_res_status <= ST_DIRTY;
                            r_res_frame  <= ram_rdata[FW-1:0];
                        end
                    end else if (ram_rdata[E_RES]) begin
                        r_res_status <= ST_RESIDENT;
                        r_res_frame  <= ram_rdata[FW-1:0];
                    end else if (r_used < fc_eff) begin
                        r_res_status <= ST_FREE;
                        r_res_frame  <= FW'(r_used);
                        r_used       <= r_used + FCW'(1);
                        r_acc        <= sat_add(r_acc, 2'd1);
                    end else begin
                        r_state <= S_DRAW;
                    end
                end
                S_DRAW: begin
                    // a full lfsr period without a hit: no victim exists
                    if (r_draws == {LFSR_W{1'b1}}) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_lfsr  <= lfsr_next(r_lfsr);
                        r_div   <= lfsr_next(r_lfsr);
                        r_rem   <= '0;
                        r_mcnt  <= '0;
                        r_draws <= r_draws + LFSR_W'(1);
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_rem  <= mod_rem;
                    r_div  <= mod_div;
                    r_mcnt <= r_mcnt + MCW'(1);
                    if (r_mcnt == MCW'(MOD_CYC - 1)) begin
                        r_state <= S_VRD;
                    end
                end
                S_VRD: begin
                    r_state <= S_VCHK;
                end
                S_VCHK: begin
                    if (ram_rdata[E_RES]) begin
                        r_res_status <= ST_EVICT;
                        r_res_frame  <= ram_rdata[FW-1:0];
                        r_victim     <= PAW'(r_rem);
                        r_res_wb     <= ram_rdata[E_DIRTY];
                        // page-in, plus write-back of a dirty victim
                        r_acc        <= sat_add(r_acc, ram_rdata[E_DIRTY] ? 2'd2 : 2'd1);
                        r_state      <= S_MAP;
                    end else begin
                        r_state <= S_DRAW;
                    end
                end
                S_MAP: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // the user must write configuration only while idle; the block does not enforce it
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PAGE_COUNT:  r_page_count  <= i_cfg_data[PAGE_COUNT_W-1:0];
                    CFG_FRAME_COUNT: r_frame_count <= i_cfg_data[FRAME_COUNT_W-1:0];
                    CFG_RANDOM_SEED: r_lfsr <= (i_cfg_data == '0) ? LFSR_W'(1) : i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // result payload, loaded with the valid flag
    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && slot_free) begin
            r_out_tdata <= {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, r_acc, r_res_wb,
                            PAGE_W'(r_victim), FRAME_O_W'(r_res_frame)};
            r_out_tuser <= r_res_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_tdata;
    assign o_m_tuser  = r_out_tuser;

endmodule

>>> rtl/core/pfr_chk.sv
module pfr_chk
    import pfr_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_m_tvalid,
    input logic                    i_m_tready,
    input logic [OUT_TDATA_W-1:0]  o_m_tdata,
    input logic [STATUS_W-1:0]     o_m_tuser
);

    logic [COUNT_W-1:0] r_last_count;
    logic [COUNT_W-1:0] count;
    logic [PAGE_W-1:0]  victim;
    logic [FRAME_O_W-1:0] frame;
    logic               wb;

    assign count  = o_m_tdata[OUT_COUNT_LSB +: COUNT_W];
    assign victim = o_m_tdata[OUT_VICTIM_LSB +: PAGE_W];
    assign frame  = o_m_tdata[OUT_FRAME_LSB +: FRAME_O_W];
    assign wb     = o_m_tdata[OUT_WB_BIT];

    // disk count shown by the last result transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_count <= '0;
        end else if (o_m_tvalid && i_m_tready) begin
            r_last_count <= count;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> count >= r_last_count)
        else $error("disk count went backward");

    a_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_IGNORED) |->
            (count == r_last_count) && (frame == '0) && (victim == '0) && !wb)
        else $error("ignored request changed state or showed data");

    a_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != ST_EVICT) |-> (victim == '0) && !wb)
        else $error("victim or write-back without eviction");

    a_evict_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_EVICT) && (r_last_count < 32'hFFFF_FFFD) |->
            count == r_last_count + (wb ? 32'd2 : 32'd1))
        else $error("eviction disk count mismatch");

endmodule

bind page_fault_random_replacement pfr_chk u_pfr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tuser   (o_m_tuser)
);
